@@ rtl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sorted set insert block: table size,
// field widths, operation codes and the request, result and memory port words.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 64;
  localparam int PAY_W  = 32;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // one request word
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [IDX_W-1:0] index;
  } ssi_req_t;

  // one result word
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             existed;
    logic             full_res;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] read_key;
    logic [PAY_W-1:0] read_payload;
  } ssi_res_t;

  // one table entry as stored
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } ssi_entry_t;

  // memory access from the controller
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    ssi_entry_t        wdata;
  } ssi_mem_req_t;

endpackage

`default_nettype wire

@@ rtl/sorted_set_insert_top.sv @@
// ----------------------------------------------------------------------------
// sorted_set_insert_top
// Sorted table of up to 64 distinct 64-bit keys with 32-bit payloads.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// res_o for one cycle with done_o high and must be captured then, since the
// block cannot be held off. A read fetches the entry, then shows the result.
// An insert runs a binary search (at most 7 probes over the single-port read
// of the entry memory), closes the search, does the duplicate check when the
// search stops on a stored entry, then moves every later entry up one per
// cycle, places the new key and shows the result. busy drops in the cycle the
// result is shown, so the next word can be taken right then. The table
// starts empty after reset; no clearing pass.
`default_nettype none

module sorted_set_insert_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  ssi_pkg::ssi_req_t req_i,
  output logic              done_o,
  output ssi_pkg::ssi_res_t res_o
);

  ssi_pkg::ssi_mem_req_t mem_req;
  ssi_pkg::ssi_entry_t   rdata;

  ssi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata)
  );

  ssi_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // a result closes an item that kept the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $fell(busy))
    else $error("result without a finished item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.count <= ssi_pkg::CNT_W'(ssi_pkg::DEPTH))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.full_res |->
      !res_o.existed && res_o.count == ssi_pkg::CNT_W'(ssi_pkg::DEPTH))
    else $error("full reported on a table that is not full");

  // shift writes and reads never hit the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("read and write to the same entry");

endmodule

`default_nettype wire

@@ rtl/ssi_ram.sv @@
// ----------------------------------------------------------------------------
// ssi_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_ram (
  input  wire                   clk_i,
  input  ssi_pkg::ssi_mem_req_t mem_req_i,
  output ssi_pkg::ssi_entry_t   rdata_o
);

  ssi_pkg::ssi_entry_t mem [ssi_pkg::DEPTH];
  ssi_pkg::ssi_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/ssi_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssi_ctrl
// Sequencer: binary search over the store, duplicate check, upward shift of
// later entries one per cycle, placement of the new entry, and entry reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  ssi_pkg::ssi_req_t     req_i,
  output logic                  done_o,
  output ssi_pkg::ssi_res_t     res_o,
  output ssi_pkg::ssi_mem_req_t mem_req_o,
  input  ssi_pkg::ssi_entry_t   rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SEARCH,
    ST_CMP,
    ST_CHECK,
    ST_SHIFT,
    ST_PLACE
  } state_e;

  localparam logic [ssi_pkg::CNT_W-1:0] FullCnt = ssi_pkg::CNT_W'(ssi_pkg::DEPTH);

  state_e                         state_q, state_d;
  ssi_pkg::ssi_req_t              req_q, req_d;
  logic [ssi_pkg::CNT_W-1:0]      count_q, count_d;
  logic [ssi_pkg::CNT_W-1:0]      lo_q, lo_d;
  logic [ssi_pkg::CNT_W-1:0]      hi_q, hi_d;
  logic [ssi_pkg::CNT_W-1:0]      mid_q, mid_d;
  logic [ssi_pkg::ADDR_W-1:0]     ptr_q, ptr_d;
  logic                           done_q, done_d;
  ssi_pkg::ssi_res_t              res_q, res_d;
  logic [ssi_pkg::CNT_W:0]        mid_sum;
  logic [ssi_pkg::CNT_W-1:0]      mid;
  logic [ssi_pkg::CNT_W-1:0]      idx_ext;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[ssi_pkg::CNT_W:1];
  assign idx_ext = ssi_pkg::CNT_W'(req_q.index);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    ptr_d     = ptr_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_req_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          lo_d  = '0;
          hi_d  = count_q;
          if (req_i.op == ssi_pkg::OP_READ) begin
            state_d = ST_RD_WAIT;
            if (ssi_pkg::CNT_W'(req_i.index) < count_q) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = ssi_pkg::ADDR_W'(req_i.index);
            end
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      ST_RD_WAIT: begin
        done_d         = 1'b1;
        state_d        = ST_IDLE;
        res_d          = '0;
        res_d.position = ssi_pkg::POS_W'(req_q.index);
        res_d.count    = count_q;
        if (idx_ext < count_q) begin
          res_d.existed      = 1'b1;
          res_d.read_key     = rdata_i.key;
          res_d.read_payload = rdata_i.payload;
        end
      end

      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = mid[ssi_pkg::ADDR_W-1:0];
          mid_d           = mid;
          state_d         = ST_CMP;
        end else if (lo_q < count_q) begin
          // lower bound found inside the table: fetch it for the equality test
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = lo_q[ssi_pkg::ADDR_W-1:0];
          state_d         = ST_CHECK;
        end else if (count_q >= FullCnt) begin
          done_d         = 1'b1;
          state_d        = ST_IDLE;
          res_d          = '0;
          res_d.position = lo_q;
          res_d.full_res = 1'b1;
          res_d.count    = count_q;
        end else begin
          state_d = ST_PLACE;
        end
      end

      ST_CMP: begin
        if (rdata_i.key < req_q.key) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SEARCH;
      end

      ST_CHECK: begin
        if (rdata_i.key == req_q.key) begin
          done_d         = 1'b1;
          state_d        = ST_IDLE;
          res_d          = '0;
          res_d.position = lo_q;
          res_d.existed  = 1'b1;
          res_d.count    = count_q;
        end else if (count_q >= FullCnt) begin
          done_d         = 1'b1;
          state_d        = ST_IDLE;
          res_d          = '0;
          res_d.position = lo_q;
          res_d.full_res = 1'b1;
          res_d.count    = count_q;
        end else begin
          // start the shift at the top entry
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ssi_pkg::ADDR_W'(count_q - 1'b1);
          ptr_d           = ssi_pkg::ADDR_W'(count_q - 1'b1);
          state_d         = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // write the entry read last cycle one place up; the next read is two
        // below the write, so the ports never touch the same entry
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q + 1'b1;
        mem_req_o.wdata = rdata_i;
        if (ptr_q == lo_q[ssi_pkg::ADDR_W-1:0]) begin
          state_d = ST_PLACE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_q - 1'b1;
          ptr_d           = ptr_q - 1'b1;
        end
      end

      ST_PLACE: begin
        mem_req_o.we            = 1'b1;
        mem_req_o.waddr         = lo_q[ssi_pkg::ADDR_W-1:0];
        mem_req_o.wdata.key     = req_q.key;
        mem_req_o.wdata.payload = req_q.payload;
        count_d                 = count_q + 1'b1;
        done_d                  = 1'b1;
        state_d                 = ST_IDLE;
        res_d                   = '0;
        res_d.position          = lo_q;
        res_d.count             = count_q + 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    ptr_q <= ptr_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ verif/ssi_table_checker.sv @@
// ----------------------------------------------------------------------------
// ssi_table_checker
// Watches the request and result channels of the sorted set insert block,
// keeps its own copy of the sorted key table, works out the result of every
// accepted request word and compares each result word field by field.
// ----------------------------------------------------------------------------

module ssi_table_checker
  import ssi_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  input  wire       busy,
  input  ssi_req_t  req_i,
  input  wire       done_o,
  input  ssi_res_t  res_o,
  output int        error_count,
  output int        pending,
  output int        placed_count,
  output int        duplicate_count,
  output int        refused_count,
  output int        read_count
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0] table_keys     [DEPTH];
  logic [PAY_W-1:0] table_payloads [DEPTH];
  int               fill;
  ssi_res_t         expected_results[$];

  initial begin
    error_count     = 0;
    pending         = 0;
    placed_count    = 0;
    duplicate_count = 0;
    refused_count   = 0;
    read_count      = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    end
  endtask

  // applies one request word to the table copy and returns its result word
  function automatic ssi_res_t table_apply(input ssi_req_t w);
    ssi_res_t r;
    int       lo;
    int       hi;
    int       mid;
    r  = '0;
    lo = 0;
    hi = fill;
    if (w.op == OP_READ) begin
      r.position = POS_W'(w.index);
      if (int'(w.index) < fill) begin
        r.existed      = 1'b1;
        r.read_key     = table_keys[w.index];
        r.read_payload = table_payloads[w.index];
      end
    end else begin
      // lower bound over the stored entries
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (table_keys[mid] < w.key) lo = mid + 1;
        else hi = mid;
      end
      r.position = POS_W'(lo);
      if (lo < fill && table_keys[lo] == w.key) begin
        r.existed = 1'b1;
      end else if (fill >= DEPTH) begin
        r.full_res = 1'b1;
      end else begin
        for (int i = fill; i > lo; i--) begin
          table_keys[i]     = table_keys[i-1];
          table_payloads[i] = table_payloads[i-1];
        end
        table_keys[lo]     = w.key;
        table_payloads[lo] = w.payload;
        fill++;
      end
    end
    r.count = CNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ssi_res_t want;
    if (!rst_ni) begin
      fill = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      // the result of the previous word can land on the edge that takes the next
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("position", res_o.position, want.position);
          check_field("existed", res_o.existed, want.existed);
          check_field("full_res", res_o.full_res, want.full_res);
          check_field("count", res_o.count, want.count);
          check_field("read_key", res_o.read_key, want.read_key);
          check_field("read_payload", res_o.read_payload, want.read_payload);
        end
      end
      if (start && !busy) begin
        want = table_apply(req_i);
        expected_results.push_back(want);
        if (req_i.op == OP_READ) read_count++;
        else if (want.existed) duplicate_count++;
        else if (want.full_res) refused_count++;
        else placed_count++;
      end
      pending <= expected_results.size();
    end
  end

endmodule

@@ verif/sorted_set_insert_top_test.sv @@
// ----------------------------------------------------------------------------
// sorted_set_insert_top_test
// Drives the sorted set insert block with a directed opening (table ends,
// duplicates, shifting inserts, reads) and then random inserts and reads that
// grow the table to full and keep working on it, with random gaps between
// words. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module sorted_set_insert_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ssi_pkg::*;

  localparam int RANDOM_WORDS = 650;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 100;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ssi_req_t req;
  logic     done;
  ssi_res_t res;

  int error_count;
  int pending;
  int placed_count;
  int duplicate_count;
  int refused_count;
  int read_count;
  int stall_cycles = 0;

  // stimulus side view of which keys are in the table
  bit [KEY_W-1:0] stored_keys[$];
  bit             stored[bit [KEY_W-1:0]];
  bit             no_idle;

  sorted_set_insert_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  ssi_table_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .req_i           (req),
    .done_o          (done),
    .res_o           (res),
    .error_count     (error_count),
    .pending         (pending),
    .placed_count    (placed_count),
    .duplicate_count (duplicate_count),
    .refused_count   (refused_count),
    .read_count      (read_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cycles in which no word moves either way
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic ssi_req_t insert_word(input bit [KEY_W-1:0] key,
                                           input bit [PAY_W-1:0] payload);
    ssi_req_t w;
    w.op      = OP_INSERT;
    w.key     = key;
    w.payload = payload;
    w.index   = IDX_W'($urandom);
    return w;
  endfunction

  function automatic ssi_req_t read_word(input int idx);
    ssi_req_t w;
    w.op      = OP_READ;
    w.key     = {$urandom, $urandom};
    w.payload = $urandom;
    w.index   = IDX_W'(idx);
    return w;
  endfunction

  // random key that is likely, not certain, to be new
  function automatic bit [KEY_W-1:0] fresh_key();
    bit [KEY_W-1:0] k;
    k = '0;
    case ($urandom_range(0, 5))
      0, 1: k = {$urandom, $urandom};
      2: begin
        for (int e = 0; e < 8; e++) k[e*8 +: 8] = 8'($urandom_range(0, 3));
      end
      3: k = 64'($urandom_range(0, 7));
      4: k = ~64'($urandom_range(0, 7));
      default: begin
        if (stored_keys.size() > 0) begin
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else begin
          k = {$urandom, $urandom};
        end
      end
    endcase
    return k;
  endfunction

  function automatic bit [KEY_W-1:0] stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic send_word(input ssi_req_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (w.op == OP_INSERT && !stored.exists(w.key) && stored_keys.size() < DEPTH) begin
      stored[w.key] = 1'b1;
      stored_keys.push_back(w.key);
    end
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int  choice;
    bit  saw_full;
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    req      = '0;
    no_idle  = 1'b0;
    saw_full = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: ends of the key range, duplicates, shifts, reads
    send_word(insert_word(64'h0101_0101_0101_0101, 32'hFFFF_FFFF));
    send_word(insert_word(64'h0, 32'h0));
    send_word(insert_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
    send_word(insert_word(64'h0, 32'h1234_5678));
    send_word(insert_word(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_word(insert_word(64'h8000_0000_0000_0000, 32'hA5A5_A5A5));
    send_word(insert_word(64'h7FFF_FFFF_FFFF_FFFF, 32'h5A5A_5A5A));
    send_word(insert_word(64'h1, 32'h0000_0001));
    send_word(insert_word(64'hFFFF_FFFF_FFFF_FFFE, 32'h8000_0000));
    send_word(insert_word(64'h0100_0000_0000_0000, 32'h0F0F_0F0F));
    send_word(insert_word(64'h0000_0000_0000_0100, 32'hF0F0_F0F0));
    send_word(read_word(0));
    send_word(read_word(1));
    send_word(read_word(stored_keys.size() - 1));
    send_word(read_word(stored_keys.size() / 2));
    send_word(insert_word(64'h0101_0101_0101_0101, 32'h0));

    // random part: grow the table to full, then keep hitting it
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      choice = $urandom_range(0, 99);
      if (stored_keys.size() < DEPTH) begin
        if (choice < 60) send_word(insert_word(fresh_key(), $urandom));
        else if (choice < 80) send_word(insert_word(stored_key(), $urandom));
        else send_word(read_word($urandom_range(0, stored_keys.size() - 1)));
      end else begin
        if (!saw_full) begin
          // first visit to a full table: both ends, a duplicate, a refusal
          saw_full = 1'b1;
          send_word(read_word(DEPTH - 1));
          send_word(read_word(0));
          send_word(insert_word(stored_key(), $urandom));
          send_word(insert_word(~stored_keys[0] ^ 64'h1, $urandom));
        end
        if (choice < 35) send_word(insert_word(fresh_key(), $urandom));
        else if (choice < 65) send_word(insert_word(stored_key(), $urandom));
        else send_word(read_word($urandom_range(0, DEPTH - 1)));
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts: %0d placed, %0d already present, %0d refused on a full table",
             placed_count + duplicate_count + refused_count, placed_count, duplicate_count,
             refused_count);
    $display("and %0d reads of stored entries; %0d mismatches", read_count, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
